### src/app_pkg.sv
// shared types and constants for the average pixel predictor codec
// no dependencies; used by every other file of the block but app_line_mem
package app_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int SAMPLE_W   = 9;
    localparam int PIXEL_W    = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int IMG_W_W    = 13;
    localparam int IMG_H_W    = 16;

    localparam logic [PIXEL_W-1:0] FIRST_PREDICTION = 8'd128;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DECODE_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd2;

    // position of one pixel inside the frame
    typedef struct packed {
        logic col_nz;
        logic row_nz;
        logic last;
    } t_pos;

endpackage

### src/app_if.sv
// stream interfaces of the predictor codec: input sample words and result words
// depends on app_pkg
interface app_in_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [app_pkg::SAMPLE_W-1:0]   sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

interface app_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [app_pkg::SAMPLE_W-1:0]   sample_out;
    logic                                  frame_last;

    modport source (output valid, output sample_out, output frame_last, input ready);
    modport sink   (input valid, input sample_out, input frame_last, output ready);
endinterface

### src/app_line_mem.sv
// previous-row line store: one write port, one read port, registered read data
// depends on nothing but its parameters
module app_line_mem #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic        i_clk,
    input  logic        i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]  o_rdata,
    input  logic        i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]  i_wdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/app_scan.sv
// raster position counters: column and row, row end and frame end detection
// depends on app_pkg
module app_scan #(
    parameter int MAX_WIDTH = app_pkg::MAX_WIDTH,
    parameter int AW        = 12
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,
    input  logic [app_pkg::IMG_W_W-1:0]   i_width,
    input  logic [app_pkg::IMG_H_W-1:0]   i_height,
    output logic [AW-1:0]                 o_addr,
    output app_pkg::t_pos                 o_pos
);

    logic [AW-1:0] r_col, n_col;
    logic [15:0]   r_row, n_row;
    logic [16:0]   col_p1, row_p1, w_eff, h_eff;
    logic          row_end, last;

    always_comb begin
        w_eff   = (i_width == '0) ? 17'd1 : 17'(i_width);
        if (w_eff > 17'(MAX_WIDTH)) begin
            w_eff = 17'(MAX_WIDTH);
        end
        h_eff   = (i_height == '0) ? 17'd1 : 17'(i_height);
        col_p1  = 17'(r_col) + 17'd1;
        row_p1  = 17'(r_row) + 17'd1;
        row_end = (col_p1 >= w_eff);
        last    = row_end && (row_p1 >= h_eff);
        if (last) begin
            n_col = '0;
            n_row = '0;
        end else if (row_end) begin
            n_col = '0;
            n_row = row_p1[15:0];
        end else begin
            n_col = col_p1[AW-1:0];
            n_row = r_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_adv) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    assign o_addr       = r_col;
    assign o_pos.col_nz = (r_col != '0);
    assign o_pos.row_nz = (r_row != '0);
    assign o_pos.last   = last;

endmodule

### src/app_calc.sv
// prediction from left and upper neighbors, residual or reconstruction
// depends on app_pkg
module app_calc (
    input  logic                                i_decode,
    input  logic signed [app_pkg::SAMPLE_W-1:0] i_sample,
    input  logic [7:0]                          i_left,
    input  logic [7:0]                          i_above,
    input  app_pkg::t_pos                       i_pos,
    output logic [7:0]                          o_pix,
    output logic signed [app_pkg::SAMPLE_W-1:0] o_result
);

    logic [8:0]         avg;
    logic [7:0]         pred;
    logic signed [10:0] recon;
    logic signed [9:0]  resid;

    always_comb begin
        avg = (9'(i_left) + 9'(i_above) + 9'd1) >> 1;
        if (i_pos.col_nz && i_pos.row_nz) begin
            pred = avg[7:0];
        end else if (i_pos.col_nz) begin
            pred = i_left;
        end else if (i_pos.row_nz) begin
            pred = i_above;
        end else begin
            pred = app_pkg::FIRST_PREDICTION;
        end

        recon = 11'(i_sample) + $signed({3'b000, pred});
        resid = '0;
        if (i_decode) begin
            if (recon < 0) begin
                o_pix = 8'd0;
            end else if (recon > 11'sd255) begin
                o_pix = 8'd255;
            end else begin
                o_pix = recon[7:0];
            end
            o_result = $signed({1'b0, o_pix});
        end else begin
            // negative pixels clamp to zero
            o_pix    = i_sample[8] ? 8'd0 : i_sample[7:0];
            resid    = $signed({2'b00, o_pix}) - $signed({2'b00, pred});
            o_result = resid[8:0];
        end
    end

endmodule

### src/average_pixel_predictor_codec_top.sv
// Average-of-neighbors pixel predictor codec, lossless, raster order.
// Channels: i_pix carries one sample word per pixel (a pixel 0..255 when
// encoding, a signed residual when decoding); o_res carries one result word
// per pixel, sample_out plus frame_last on the final pixel of the image.
// Configuration: i_cfg_we/i_cfg_idx/i_cfg_data write decode_mode (0),
// image_width (1) and image_height (2); write only while the block is idle.
// Each accepted word waits in stage 1 for the line store read, then goes to the
// output register. Throughput: one word per cycle while o_res is not stalled;
// the line store is read at accept and written back as the word leaves stage 1,
// with the value forwarded when the next word hits the same column (width of one).
// Reset (synchronous, active low): counters, left pixel and the pipeline
// clear; the line store is not cleared and needs no clearing pass, since a
// row is written before it is read while the width does not grow mid-frame.
// When o_res.ready stays low, one result waits in the output register and
// one more word is taken into the pipeline; then i_pix.ready drops.
// depends on app_pkg, app_if, app_scan, app_line_mem, app_calc
module average_pixel_predictor_codec_top #(
    parameter int MAX_WIDTH = app_pkg::MAX_WIDTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    app_in_if.sink                            i_pix,
    app_out_if.source                         o_res,
    input  logic                              i_cfg_we,
    input  logic [app_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [app_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    logic                               r_decode;
    logic [app_pkg::IMG_W_W-1:0]        r_width;
    logic [app_pkg::IMG_H_W-1:0]        r_height;

    logic                               in_acc, s1_adv;
    logic [AW-1:0]                      scan_addr;
    app_pkg::t_pos                      scan_pos;

    logic                               r_s1_valid;
    logic signed [app_pkg::SAMPLE_W-1:0] r_s1_sample;
    app_pkg::t_pos                      r_s1_pos;
    logic [AW-1:0]                      r_s1_addr;
    logic                               r_s1_fwd;
    logic [7:0]                         r_s1_fwd_pix;
    logic [7:0]                         r_left;

    logic [7:0]                         mem_rdata, above, calc_pix;
    logic signed [app_pkg::SAMPLE_W-1:0] calc_result;

    logic                               r_out_valid;
    logic signed [app_pkg::SAMPLE_W-1:0] r_out_sample;
    logic                               r_out_last;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decode <= 1'b0;
            r_width  <= 13'd1;
            r_height <= 16'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                app_pkg::CFG_DECODE_MODE:  r_decode <= i_cfg_data[0];
                app_pkg::CFG_IMAGE_WIDTH:  r_width  <= i_cfg_data[app_pkg::IMG_W_W-1:0];
                app_pkg::CFG_IMAGE_HEIGHT: r_height <= i_cfg_data[app_pkg::IMG_H_W-1:0];
                default: ;
            endcase
        end
    end

    assign s1_adv      = r_s1_valid && (!r_out_valid || o_res.ready);
    assign i_pix.ready = !r_s1_valid || s1_adv;
    assign in_acc      = i_pix.valid && i_pix.ready;

    app_scan #(
        .MAX_WIDTH (MAX_WIDTH),
        .AW        (AW)
    ) u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (in_acc),
        .i_width  (r_width),
        .i_height (r_height),
        .o_addr   (scan_addr),
        .o_pos    (scan_pos)
    );

    app_line_mem #(
        .DEPTH (MAX_WIDTH),
        .AW    (AW)
    ) u_line_mem (
        .i_clk   (i_clk),
        .i_re    (in_acc),
        .i_raddr (scan_addr),
        .o_rdata (mem_rdata),
        .i_we    (s1_adv),
        .i_waddr (r_s1_addr),
        .i_wdata (calc_pix)
    );

    // stage 1: line store read in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_pix.ready) begin
            r_s1_valid <= i_pix.valid;
        end
    end

    // the word ahead writes the same column this cycle: take its pixel instead
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_sample  <= i_pix.sample_in;
            r_s1_pos     <= scan_pos;
            r_s1_addr    <= scan_addr;
            r_s1_fwd     <= s1_adv && (r_s1_addr == scan_addr);
            r_s1_fwd_pix <= calc_pix;
        end
    end

    assign above = r_s1_fwd ? r_s1_fwd_pix : mem_rdata;

    app_calc u_calc (
        .i_decode (r_decode),
        .i_sample (r_s1_sample),
        .i_left   (r_left),
        .i_above  (above),
        .i_pos    (r_s1_pos),
        .o_pix    (calc_pix),
        .o_result (calc_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else if (s1_adv) begin
            r_left <= calc_pix;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_sample <= calc_result;
            r_out_last   <= r_s1_pos.last;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.sample_out = r_out_sample;
    assign o_res.frame_last = r_out_last;

endmodule

### src/app_checker.sv
// port-level checks of the predictor codec, bound to the top level
// depends on app_pkg and average_pixel_predictor_codec_top
module app_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_out_valid,
    input  logic                                i_out_ready,
    input  logic signed [app_pkg::SAMPLE_W-1:0] i_out_sample,
    input  logic                                i_out_last,
    input  logic                                i_cfg_we,
    input  logic [app_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [app_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    logic r_decode;

    // mirror of the mode register, seen from the configuration port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decode <= 1'b0;
        end else if (i_cfg_we && (i_cfg_idx == app_pkg::CFG_DECODE_MODE)) begin
            r_decode <= i_cfg_data[0];
        end
    end

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result word valid right after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_sample) && $stable(i_out_last))
        else $error("stalled result word changed");

    a_decode_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && r_decode |-> !i_out_sample[8])
        else $error("reconstructed pixel outside 0..255");

    a_encode_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !r_decode |-> (i_out_sample != 9'sh100))
        else $error("residual below -255");

endmodule

bind average_pixel_predictor_codec_top app_checker u_app_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_res.valid),
    .i_out_ready  (o_res.ready),
    .i_out_sample (o_res.sample_out),
    .i_out_last   (o_res.frame_last),
    .i_cfg_we     (i_cfg_we),
    .i_cfg_idx    (i_cfg_idx),
    .i_cfg_data   (i_cfg_data)
);

### tb/tb_average_pixel_predictor_codec_top.sv
`timescale 1ns / 1ps
// self-checking testbench for average_pixel_predictor_codec_top: a clocked driver and
// monitor around the block, with an in-bench predictor of the average-of-neighbors codec
// depends on app_pkg, app_if and the block's top level
module tb_average_pixel_predictor_codec_top;

    localparam int STALL_LIMIT = 2000;
    localparam int RANDOM_WORDS = 750;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic signed [app_pkg::SAMPLE_W-1:0] sample;
        logic                                last;
    } t_coded;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [app_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [app_pkg::CFG_DATA_W-1:0] i_cfg_data;

    app_in_if  pix_if ();
    app_out_if res_if ();

    average_pixel_predictor_codec_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pix      (pix_if),
        .o_res      (res_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // words waiting for the driver, and coded words waiting for the block
    logic signed [app_pkg::SAMPLE_W-1:0] pending_q[$];
    t_coded                              coded_q[$];

    // predictor state and its copy of the registers
    logic [app_pkg::PIXEL_W-1:0] line_mem [0:app_pkg::MAX_WIDTH-1];
    logic [app_pkg::PIXEL_W-1:0] left_pix;
    logic [11:0]                 col_cnt;
    logic [15:0]                 row_cnt;
    logic                        m_decode;
    logic [app_pkg::IMG_W_W-1:0] m_width;
    logic [app_pkg::IMG_H_W-1:0] img_height;
    // columns 0..col_hw-1 of the line store have been written
    int                          col_hw;

    int tx_max, rx_max, tx_wait, rx_wait, rx_hold, rx_hold_req;
    int stall_cycles, fail_cnt;
    int words_in, decode_words, frames_done, cfg_writes, phases;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic int clamp_pixel(input int v);
        if (v < 0) return 0;
        if (v > 255) return 255;
        return v;
    endfunction

    // one pixel step of the codec: prediction, coding, line store and counters
    function automatic t_coded predict_sample(input logic signed [app_pkg::SAMPLE_W-1:0] s);
        t_coded r;
        int     w, h, up, pred, pix, diff;
        bit     row_end;
        w = int'(m_width);
        if (w == 0) w = 1;
        else if (w > app_pkg::MAX_WIDTH) w = app_pkg::MAX_WIDTH;
        h = int'(img_height);
        if (h == 0) h = 1;
        up = int'(line_mem[col_cnt]);
        if (col_cnt != 0 && row_cnt != 0) pred = (int'(left_pix) + up + 1) >> 1;
        else if (col_cnt != 0) pred = int'(left_pix);
        else if (row_cnt != 0) pred = up;
        else pred = int'(app_pkg::FIRST_PREDICTION);
        if (m_decode) begin
            pix  = clamp_pixel(int'(s) + pred);
            diff = pix;
        end else begin
            pix  = clamp_pixel(int'(s));
            diff = pix - pred;
        end
        line_mem[col_cnt] = pix[app_pkg::PIXEL_W-1:0];
        if (int'(col_cnt) >= col_hw) col_hw = int'(col_cnt) + 1;
        left_pix = pix[app_pkg::PIXEL_W-1:0];
        row_end = (int'(col_cnt) + 1 >= w);
        r.last = row_end && (int'(row_cnt) + 1 >= h);
        if (r.last) begin
            col_cnt = '0;
            row_cnt = '0;
        end else if (row_end) begin
            col_cnt = '0;
            row_cnt = row_cnt + 16'd1;
        end else begin
            col_cnt = col_cnt + 12'd1;
        end
        r.sample = diff[app_pkg::SAMPLE_W-1:0];
        return r;
    endfunction

    function automatic logic signed [app_pkg::SAMPLE_W-1:0] rand_sample(input bit decoding);
        int v;
        if (decoding) begin
            case ($urandom_range(0, 9))
                0: begin
                    case ($urandom_range(0, 2))
                        0: v = -256;
                        1: v = -255;
                        default: v = 255;
                    endcase
                end
                1, 2, 3, 4: v = int'($urandom_range(0, 16)) - 8;
                default: v = int'($urandom_range(0, 510)) - 255;
            endcase
        end else begin
            case ($urandom_range(0, 15))
                0: v = -int'($urandom_range(1, 256));
                1: v = 0;
                2: v = 255;
                default: v = int'($urandom_range(0, 255));
            endcase
        end
        return v[app_pkg::SAMPLE_W-1:0];
    endfunction

    // driver: one word at a time, random gap after each accepted word
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pix_if.valid <= 1'b0;
            tx_wait = 0;
        end else if (!pix_if.valid || pix_if.ready) begin
            if (tx_wait != 0) begin
                pix_if.valid <= 1'b0;
                tx_wait--;
            end else if (pending_q.size() != 0) begin
                pix_if.valid     <= 1'b1;
                pix_if.sample_in <= pending_q.pop_front();
                tx_wait = $urandom_range(0, tx_max);
            end else begin
                pix_if.valid <= 1'b0;
            end
        end
    end

    // result sink: per-word stall plus an occasional long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            rx_wait = 0;
            rx_hold = 0;
        end else begin
            if (rx_hold_req != 0) begin
                rx_hold = rx_hold_req;
                rx_hold_req = 0;
            end
            if (res_if.valid && res_if.ready) rx_wait = $urandom_range(0, rx_max);
            if (rx_hold != 0) begin
                res_if.ready <= 1'b0;
                rx_hold--;
            end else if (rx_wait != 0) begin
                res_if.ready <= 1'b0;
                rx_wait--;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    // monitor: predict on input accept, compare on output accept
    always @(posedge i_clk) begin
        t_coded exp_w;
        if (i_rst_n) begin
            if (pix_if.valid && pix_if.ready) begin
                coded_q.push_back(predict_sample(pix_if.sample_in));
                words_in++;
                if (m_decode) decode_words++;
            end
            if (res_if.valid && res_if.ready) begin
                if (res_if.frame_last) frames_done++;
                if (coded_q.size() == 0) begin
                    $error("result word with no pending prediction: sample_out %0d",
                           res_if.sample_out);
                    fail_cnt++;
                end else begin
                    exp_w = coded_q.pop_front();
                    if (res_if.sample_out !== exp_w.sample) begin
                        $error("sample_out: expected %0d, got %0d",
                               exp_w.sample, res_if.sample_out);
                        fail_cnt++;
                    end
                    if (res_if.frame_last !== exp_w.last) begin
                        $error("frame_last: expected %0b, got %0b",
                               exp_w.last, res_if.frame_last);
                        fail_cnt++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    task automatic offer(input int v);
        pending_q.push_back(v[app_pkg::SAMPLE_W-1:0]);
    endtask

    task automatic queue_words(input int n);
        repeat (n) pending_q.push_back(rand_sample(m_decode));
    endtask

    // block is idle once every word went in and every result came out
    task automatic wait_drained;
        do @(negedge i_clk);
        while (pending_q.size() != 0 || pix_if.valid || coded_q.size() != 0);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [app_pkg::CFG_IDX_W-1:0] idx,
                             input int unsigned val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val[app_pkg::CFG_DATA_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            app_pkg::CFG_DECODE_MODE:  m_decode   = val[0];
            app_pkg::CFG_IMAGE_WIDTH:  m_width    = val[app_pkg::IMG_W_W-1:0];
            app_pkg::CFG_IMAGE_HEIGHT: img_height = val[app_pkg::IMG_H_W-1:0];
            default: ;
        endcase
        cfg_writes++;
        @(negedge i_clk);
    endtask

    initial begin
        int n, rand_words, w_eff_val;
        int unsigned w_val, h_val;
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = '0;
        i_cfg_data       = '0;
        for (int i = 0; i < app_pkg::MAX_WIDTH; i++) line_mem[i] = '0;
        left_pix = '0;
        col_cnt  = '0;
        row_cnt  = '0;
        col_hw   = 0;
        m_decode = 1'b0;
        m_width    = app_pkg::IMG_W_W'(1);
        img_height = app_pkg::IMG_H_W'(1);
        tx_max = 17;
        rx_max = 17;
        rx_hold_req = 0;
        stall_cycles = 0;
        fail_cnt = 0;
        words_in = 0;
        decode_words = 0;
        frames_done = 0;
        cfg_writes = 0;
        phases = 0;
        rand_words = 0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset sizes are 1x1: every word is a frame predicted from 128
        offer(0);
        offer(255);
        wait_drained();

        // zero sizes act as one; negative encode pixels clamp to zero
        cfg_write(app_pkg::CFG_IMAGE_WIDTH, 0);
        cfg_write(app_pkg::CFG_IMAGE_HEIGHT, 0);
        offer(-1);
        offer(-256);
        wait_drained();

        // 3x2 encode: top row, left column and the averaged interior
        cfg_write(app_pkg::CFG_IMAGE_WIDTH, 3);
        cfg_write(app_pkg::CFG_IMAGE_HEIGHT, 2);
        offer(0);
        offer(255);
        offer(-7);
        offer(255);
        offer(0);
        offer(17);
        wait_drained();

        // 2x2 decode with overflow and underflow of the reconstruction
        cfg_write(app_pkg::CFG_DECODE_MODE, 1);
        cfg_write(app_pkg::CFG_IMAGE_WIDTH, 2);
        offer(255);
        offer(-256);
        offer(-255);
        offer(255);
        wait_drained();

        // tallest frame, mode flipped mid-frame, then height cut below the row count
        cfg_write(app_pkg::CFG_IMAGE_WIDTH, 3);
        cfg_write(app_pkg::CFG_IMAGE_HEIGHT, 65535);
        offer(10);
        offer(-3);
        offer(200);
        offer(5);
        wait_drained();
        cfg_write(app_pkg::CFG_DECODE_MODE, 0);
        offer(90);
        offer(255);
        wait_drained();
        cfg_write(app_pkg::CFG_IMAGE_HEIGHT, 2);
        offer(1);
        offer(2);
        offer(3);
        wait_drained();

        // random phases; sizes may change mid-frame, but below the top row the
        // width only grows over columns that were written already
        while (rand_words < RANDOM_WORDS) begin
            phases++;
            if ($urandom_range(0, 1) != 0)
                cfg_write(app_pkg::CFG_DECODE_MODE, $urandom_range(0, 1));
            if ($urandom_range(0, 2) == 0) begin
                case ($urandom_range(0, 19))
                    0: w_val = 0;
                    1: w_val = 1;
                    2: w_val = app_pkg::MAX_WIDTH;
                    3: w_val = $urandom_range(app_pkg::MAX_WIDTH + 1, 8191);
                    4, 5, 6, 7: w_val = $urandom_range(9, 40);
                    default: w_val = $urandom_range(2, 8);
                endcase
                if (w_val == 0) w_eff_val = 1;
                else if (w_val > app_pkg::MAX_WIDTH) w_eff_val = app_pkg::MAX_WIDTH;
                else w_eff_val = int'(w_val);
                if (row_cnt != 0 && w_eff_val > col_hw) w_val = unsigned'(col_hw);
                cfg_write(app_pkg::CFG_IMAGE_WIDTH, w_val);
            end
            if ($urandom_range(0, 2) == 0) begin
                case ($urandom_range(0, 15))
                    0: h_val = 0;
                    1: h_val = 1;
                    2: h_val = 65535;
                    default: h_val = $urandom_range(2, 6);
                endcase
                cfg_write(app_pkg::CFG_IMAGE_HEIGHT, h_val);
            end
            tx_max = ($urandom_range(0, 3) == 0) ? 0 : 17;
            rx_max = ($urandom_range(0, 3) == 0) ? 0 : 17;
            n = $urandom_range(5, 60);
            if (phases == 3) begin
                // sink holds off while the driver keeps pushing
                tx_max = 0;
                n = 60;
                rx_hold_req = HOLD_CYCLES;
            end
            queue_words(n);
            rand_words += n;
            wait_drained();
        end

        $display("coded %0d words (%0d decoded) over %0d random phases, %0d frames closed",
                 words_in, decode_words, phases, frames_done);
        $display("%0d register writes, %0d mismatches", cfg_writes, fail_cnt);
        if (fail_cnt == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
